@@ rtl/ebpm_pkg.sv @@
// Shared types and constants for the EMA baseline peak meter.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ebpm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int ALPHA_W  = 16;
  localparam int BLEN_W   = 8;
  localparam int FRAC_W   = 16;
  localparam int BASE_W   = SAMPLE_W + FRAC_W;   // unsigned Q10.16
  localparam int OMA_W    = ALPHA_W + 1;         // 1.0 - alpha, up to 65536
  localparam int BYTE_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 1'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd655;
  localparam logic [BLEN_W-1:0]  BLEN_RST  = 8'd25;
  localparam logic [OMA_W-1:0]   OMA_ONE   = 17'd65536;

  // report byte positions
  localparam int RPT_IDX_W = 3;
  localparam logic [RPT_IDX_W-1:0] RPT_FRAME0 = 3'd0;
  localparam logic [RPT_IDX_W-1:0] RPT_FRAME1 = 3'd1;
  localparam logic [RPT_IDX_W-1:0] RPT_FRAME2 = 3'd2;
  localparam logic [RPT_IDX_W-1:0] RPT_FRAME3 = 3'd3;
  localparam logic [RPT_IDX_W-1:0] RPT_PEAK_LO = 3'd4;
  localparam logic [RPT_IDX_W-1:0] RPT_PEAK_HI = 3'd5;

  localparam logic [BYTE_W-1:0] FRAME_B0 = 8'd1;
  localparam logic [BYTE_W-1:0] FRAME_B1 = 8'd2;
  localparam logic [BYTE_W-1:0] FRAME_B2 = 8'd3;
  localparam logic [BYTE_W-1:0] FRAME_B3 = 8'd4;

  // one classified sample on its way from front to back
  typedef struct packed {
    logic [BASE_W-1:0]   as_prod;   // alpha * sample, unsigned Q10.16
    logic [SAMPLE_W-1:0] sample;
    logic                blk_end;   // sample closes a block
  } q_entry_t;

endpackage

`default_nettype wire

@@ rtl/ebpm_ifs.sv @@
// Valid/ready channel interfaces for sample input and report byte output.
// Depends on ebpm_pkg for field widths.
`default_nettype none

interface ebpm_in_if;
  logic                           valid;
  logic                           ready;
  logic [ebpm_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ebpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [ebpm_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/ebpm_front.sv @@
// Front end: config registers, sample accept, alpha*sample product, block count.
// Depends on ebpm_pkg and ebpm_in_if.
`default_nettype none

module ebpm_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ebpm_in_if.sink                               in_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ebpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ebpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             q_full,
  output ebpm_pkg::q_entry_t                    q_wdata,
  output logic                                  q_push,
  output logic [ebpm_pkg::OMA_W-1:0]            oma
);

  logic [ebpm_pkg::ALPHA_W-1:0] alpha_r;
  logic [ebpm_pkg::OMA_W-1:0]   oma_r;
  logic [ebpm_pkg::BLEN_W-1:0]  blen_r;
  logic [ebpm_pkg::BLEN_W-1:0]  cnt_r;
  logic [ebpm_pkg::BLEN_W-1:0]  cnt_nxt;
  logic [ebpm_pkg::BLEN_W-1:0]  len_eff;
  logic                         blk_end;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ebpm_pkg::ALPHA_RST;
      oma_r   <= ebpm_pkg::OMA_ONE - ebpm_pkg::OMA_W'(ebpm_pkg::ALPHA_RST);
      blen_r  <= ebpm_pkg::BLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebpm_pkg::REG_ALPHA: begin
          alpha_r <= cfg_wdata[ebpm_pkg::ALPHA_W-1:0];
          oma_r   <= ebpm_pkg::OMA_ONE - ebpm_pkg::OMA_W'(cfg_wdata[ebpm_pkg::ALPHA_W-1:0]);
        end
        ebpm_pkg::REG_BLOCK_LEN: begin
          blen_r <= cfg_wdata[ebpm_pkg::BLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign oma         = oma_r;

  // zero length behaves as one
  assign len_eff = (blen_r == '0) ? ebpm_pkg::BLEN_W'(1) : blen_r;
  assign blk_end = ({1'b0, cnt_r} + 9'd1) >= {1'b0, len_eff};
  assign cnt_nxt = blk_end ? '0 : cnt_r + ebpm_pkg::BLEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    q_wdata.as_prod = ebpm_pkg::BASE_W'(alpha_r) * ebpm_pkg::BASE_W'(in_ch.sample);
    q_wdata.sample  = in_ch.sample;
    q_wdata.blk_end = blk_end;
  end

  a_cnt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && blk_end) |=> (cnt_r == '0))
    else $error("block count did not clear after block end");

endmodule

`default_nettype wire

@@ rtl/ebpm_fifo.sv @@
// Small register FIFO decoupling the front end from the back end.
// Depends on ebpm_pkg for the entry type.
`default_nettype none

module ebpm_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ebpm_pkg::q_entry_t wdata,
  output logic                    full,
  input  wire logic               pop,
  output logic                    rvalid,
  output ebpm_pkg::q_entry_t      rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  ebpm_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/ebpm_back.sv @@
// Back end: baseline update, peak tracking and six-byte report serializer.
// Depends on ebpm_pkg and ebpm_out_if.
`default_nettype none

module ebpm_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire ebpm_pkg::q_entry_t          q_rdata,
  output logic                             q_pop,
  input  wire logic [ebpm_pkg::OMA_W-1:0]  oma,
  ebpm_out_if.source                       out_ch
);

  localparam int PW = ebpm_pkg::OMA_W + ebpm_pkg::BASE_W;

  logic [ebpm_pkg::BASE_W-1:0]    baseline_r;
  logic [ebpm_pkg::BASE_W-1:0]    baseline_nxt;
  logic [PW-1:0]                  decay_prod;
  logic                           v1_r;
  logic [ebpm_pkg::SAMPLE_W-1:0]  s1_r;
  logic                           end1_r;
  logic                           retire1;

  logic [ebpm_pkg::SAMPLE_W-1:0]  peak_r;
  logic [ebpm_pkg::SAMPLE_W-1:0]  base_int;
  logic [ebpm_pkg::SAMPLE_W-1:0]  diff;
  logic [ebpm_pkg::SAMPLE_W-1:0]  peak_max;

  logic                            rep_busy_r;
  logic [ebpm_pkg::RPT_IDX_W-1:0]  rep_idx_r;
  logic [ebpm_pkg::SAMPLE_W-1:0]   rep_peak_r;
  logic                            out_xfer;
  logic                            rep_done;

  // baseline' = alpha*s + floor((1 - alpha) * baseline)   (all Q16)
  assign decay_prod   = PW'(oma) * PW'(baseline_r);
  assign baseline_nxt = q_rdata.as_prod
                      + decay_prod[ebpm_pkg::FRAC_W +: ebpm_pkg::BASE_W];

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign rep_done = out_xfer && (rep_idx_r == ebpm_pkg::RPT_PEAK_HI);
  assign retire1  = v1_r && (!end1_r || !rep_busy_r || rep_done);
  assign q_pop    = q_valid && (!v1_r || retire1);

  // stage 1: baseline update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      baseline_r <= '0;
    end else if (q_pop) begin
      v1_r       <= 1'b1;
      baseline_r <= baseline_nxt;
    end else if (retire1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r   <= q_rdata.sample;
      end1_r <= q_rdata.blk_end;
    end
  end

  // stage 2: peak against integer part of the new baseline
  assign base_int = baseline_r[ebpm_pkg::FRAC_W +: ebpm_pkg::SAMPLE_W];
  assign diff     = (s1_r >= base_int) ? (s1_r - base_int) : (base_int - s1_r);
  assign peak_max = (diff > peak_r) ? diff : peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (retire1) begin
      peak_r <= end1_r ? '0 : peak_max;
    end
  end

  // report serializer; a new report may start on the cycle the old one ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_busy_r <= 1'b0;
      rep_idx_r  <= ebpm_pkg::RPT_FRAME0;
    end else if (retire1 && end1_r) begin
      rep_busy_r <= 1'b1;
      rep_idx_r  <= ebpm_pkg::RPT_FRAME0;
    end else if (rep_done) begin
      rep_busy_r <= 1'b0;
      rep_idx_r  <= ebpm_pkg::RPT_FRAME0;
    end else if (out_xfer) begin
      rep_idx_r <= rep_idx_r + ebpm_pkg::RPT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (retire1 && end1_r) begin
      rep_peak_r <= peak_max;
    end
  end

  assign out_ch.valid = rep_busy_r;
  assign out_ch.last  = (rep_idx_r == ebpm_pkg::RPT_PEAK_HI);

  always_comb begin
    unique case (rep_idx_r)
      ebpm_pkg::RPT_FRAME0:  out_ch.out_byte = ebpm_pkg::FRAME_B0;
      ebpm_pkg::RPT_FRAME1:  out_ch.out_byte = ebpm_pkg::FRAME_B1;
      ebpm_pkg::RPT_FRAME2:  out_ch.out_byte = ebpm_pkg::FRAME_B2;
      ebpm_pkg::RPT_FRAME3:  out_ch.out_byte = ebpm_pkg::FRAME_B3;
      ebpm_pkg::RPT_PEAK_LO: out_ch.out_byte = rep_peak_r[ebpm_pkg::BYTE_W-1:0];
      ebpm_pkg::RPT_PEAK_HI: out_ch.out_byte =
        ebpm_pkg::BYTE_W'(rep_peak_r[ebpm_pkg::SAMPLE_W-1:ebpm_pkg::BYTE_W]);
      default:               out_ch.out_byte = '0;
    endcase
  end

  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (retire1 && end1_r) |=> (rep_busy_r && rep_idx_r == ebpm_pkg::RPT_FRAME0))
    else $error("report did not start at block end");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    rep_busy_r |-> (rep_idx_r <= ebpm_pkg::RPT_PEAK_HI))
    else $error("report index out of range");

  a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && end1_r && rep_busy_r && !rep_done) |-> !retire1)
    else $error("block end retired over a live report");

endmodule

`default_nettype wire

@@ rtl/ema_baseline_peak_meter.sv @@
// Top level of the EMA baseline peak meter: front end, queue and back end.
// Depends on ebpm_pkg, ebpm_ifs, ebpm_front, ebpm_fifo and ebpm_back.
//
// Takes one 10-bit sample per transfer on in_ch and keeps an exponential
// moving average baseline in unsigned Q10.16, moved toward each sample by
// the Q0.16 weight alpha with truncation. The distance between the sample
// and the integer part of the updated baseline feeds a running peak. Every
// block_length samples (zero counts as one) the block sends a six-byte
// report on out_ch: 1, 2, 3, 4, peak low byte, peak high byte, with last
// on the sixth; the peak and the sample count then clear while the baseline
// carries on. Rate: one sample per clock while no report is pending; each
// report holds the output for six transfers, and a block-closing sample
// waits in stage 1 until the previous report has gone. The baseline loop
// is one (1 - alpha) * baseline multiply plus an add per cycle; alpha *
// sample is formed on accept. A queue of QUEUE_DEPTH entries lets the
// input keep flowing while a report drains. Reports start after the queue
// and stage 1. Config writes (cfg_we, cfg_index 0 = alpha, 1 =
// block_length) apply to the next sample and must come while idle.
`default_nettype none

module ema_baseline_peak_meter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ebpm_in_if.sink                               in_ch,
  ebpm_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ebpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ebpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ebpm_pkg::q_entry_t           q_wdata;
  ebpm_pkg::q_entry_t           q_rdata;
  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  logic [ebpm_pkg::OMA_W-1:0]   oma;

  // accept, product alpha * sample, block end flag
  ebpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_wdata   (q_wdata),
    .q_push    (q_push),
    .oma       (oma)
  );

  ebpm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // baseline, peak, report bytes
  ebpm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .oma     (oma),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
